@@ src/life_pkg.sv @@
package life_pkg;

    // Field widths
    localparam int ROW_BITS   = 64;
    localparam int WIDTH_BITS = 7;

    // Defaults
    localparam int                    MAX_WIDTH_DEF = 64;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET   = 7'd32;

    // Neighbour counts of the B3/S23 rule
    localparam logic [3:0] NB_BIRTH   = 4'd3;
    localparam logic [3:0] NB_SURVIVE = 4'd2;

    // Bits one column shows to its neighbours
    typedef struct packed {
        logic upper;
        logic middle;
        logic cur;
    } nb_t;

    // Row update command for the cells
    typedef struct packed {
        logic advance;
        logic clear;
        logic first;
    } cell_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                grid_done;
        logic                run_end;
    } result_t;

    // Queue load command
    typedef struct packed {
        logic accept;
        logic has_first;
        logic has_second;
    } q_push_t;

    function automatic logic life_rule(input logic alive, input logic [3:0] n);
        return (n == NB_BIRTH) || (alive && (n == NB_SURVIVE));
    endfunction

endpackage

@@ src/life_cellular_automaton_row_step_core.sv @@
// A transaction's results are registered in the two-entry output queue and appear in the cycle
// after it is accepted. Throughput: one row per cycle while the receiver does not stall, set by the
// per-column cells working in parallel; the bottom row of a grid with held rows yields two results,
// and the input is held off while the second drains from the output queue.
// Reset: held rows and row count clear (new grid), row_width returns to 32,
// output queue empties.
module life_cellular_automaton_row_step_core
    import life_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [WIDTH_BITS-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ROW_BITS-1:0]   row_cells,
    input  logic                  last_row,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROW_BITS-1:0]   next_cells,
    output logic                  grid_done,
    output logic                  run_end
);

    logic [WIDTH_BITS-1:0] width_reg;
    logic [WIDTH_BITS-1:0] width_eff;
    logic [1:0]            held_reg;
    logic [1:0]            held_next;
    logic                  held_nz;
    logic                  accept;
    logic                  space_ok;
    cell_ctrl_t            ctrl;
    q_push_t               push;
    result_t               first_res;
    result_t               second_res;
    result_t               head;
    nb_t                   own_nb [MAX_WIDTH];
    logic [MAX_WIDTH-1:0]  next_a;
    logic [MAX_WIDTH-1:0]  next_b;

    assign in_stall = !space_ok;
    assign accept   = in_valid && space_ok;
    assign held_nz  = (held_reg != 2'd0);

    // Saturate the configured width
    assign width_eff = (width_reg > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH) : width_reg;

    assign ctrl.advance = accept;
    assign ctrl.clear   = last_row;
    assign ctrl.first   = !held_nz;

    // Chain of column cells
    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_col
        nb_t left_nb;
        nb_t right_nb;
        if (i == 0)
        begin : g_left_edge
            assign left_nb = '0;
        end
        else
        begin : g_left
            assign left_nb = own_nb[i-1];
        end
        if (i == MAX_WIDTH - 1)
        begin : g_right_edge
            assign right_nb = '0;
        end
        else
        begin : g_right
            assign right_nb = own_nb[i+1];
        end
        life_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .col_en   (WIDTH_BITS'(i) < width_eff),
            .cur_bit  (row_cells[i]),
            .left_nb  (left_nb),
            .right_nb (right_nb),
            .own_nb   (own_nb[i]),
            .next_a   (next_a[i]),
            .next_b   (next_b[i])
        );
    end

    // Select results: row above first and bottom row second, or the bottom row alone when no rows are held
    always_comb
    begin
        if (held_nz)
        begin
            first_res.cells     = ROW_BITS'(next_a);
            first_res.grid_done = 1'b0;
            first_res.run_end   = !last_row;
        end
        else
        begin
            first_res.cells     = ROW_BITS'(next_b);
            first_res.grid_done = 1'b1;
            first_res.run_end   = 1'b1;
        end
        second_res.cells     = ROW_BITS'(next_b);
        second_res.grid_done = 1'b1;
        second_res.run_end   = 1'b1;
    end

    assign push.accept     = accept;
    assign push.has_first  = last_row || held_nz;
    assign push.has_second = last_row && held_nz;

    life_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .first_res  (first_res),
        .second_res (second_res),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .head       (head),
        .space_ok   (space_ok)
    );

    assign next_cells = head.cells;
    assign grid_done  = head.grid_done;
    assign run_end    = head.run_end;

    // Count held rows; drop back to a new grid after the bottom row
    always_comb
    begin
        held_next = held_reg;
        if (accept)
        begin
            if (last_row)
            begin
                held_next = 2'd0;
            end
            else if (!held_nz)
            begin
                held_next = 2'd1;
            end
            else
            begin
                held_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 2'd0;
            width_reg <= WIDTH_RESET;
        end
        else
        begin
            held_reg <= held_next;
            if (cfg_wen)
            begin
                width_reg <= cfg_wdata;
            end
        end
    end

endmodule

@@ src/life_cell.sv @@
module life_cell
    import life_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       col_en,
    input  logic       cur_bit,
    input  nb_t        left_nb,
    input  nb_t        right_nb,
    output nb_t        own_nb,
    output logic       next_a,
    output logic       next_b
);

    logic upper_reg;
    logic upper_next;
    logic middle_reg;
    logic middle_next;
    logic [3:0] count_a;
    logic [3:0] count_b;

    // Mask held and incoming bits to the columns in use
    assign own_nb.upper  = upper_reg & col_en;
    assign own_nb.middle = middle_reg & col_en;
    assign own_nb.cur    = cur_bit & col_en;

    // Count neighbours: row above (upper, middle, cur) and bottom row (middle, cur, dead)
    assign count_a = {3'b000, left_nb.upper} + {3'b000, own_nb.upper}
                   + {3'b000, right_nb.upper} + {3'b000, left_nb.middle}
                   + {3'b000, right_nb.middle} + {3'b000, left_nb.cur}
                   + {3'b000, own_nb.cur} + {3'b000, right_nb.cur};
    assign count_b = {3'b000, left_nb.middle} + {3'b000, own_nb.middle}
                   + {3'b000, right_nb.middle} + {3'b000, left_nb.cur}
                   + {3'b000, right_nb.cur};

    assign next_a = life_rule(own_nb.middle, count_a) & col_en;
    assign next_b = life_rule(own_nb.cur, count_b) & col_en;

    // Advance the held rows on each accepted transaction
    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (ctrl.advance)
        begin
            if (ctrl.clear)
            begin
                upper_next  = 1'b0;
                middle_next = 1'b0;
            end
            else if (ctrl.first)
            begin
                upper_next  = 1'b0;
                middle_next = own_nb.cur;
            end
            else
            begin
                upper_next  = middle_reg;
                middle_next = own_nb.cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
        end
    end

endmodule

@@ src/life_out_queue.sv @@
module life_out_queue
    import life_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t push,
    input  result_t first_res,
    input  result_t second_res,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t head,
    output logic    space_ok
);

    logic    head_valid_reg;
    logic    head_valid_next;
    logic    tail_valid_reg;
    logic    tail_valid_next;
    result_t head_reg;
    result_t head_next;
    result_t tail_reg;
    result_t tail_next;
    logic    pop;

    assign pop       = head_valid_reg && !out_stall;
    // Room for two results once this cycle's pop is taken
    assign space_ok  = !head_valid_reg || (!tail_valid_reg && !out_stall);
    assign out_valid = head_valid_reg;
    assign head      = head_reg;

    // Load on accept, otherwise shift the tail forward on pop
    always_comb
    begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        if (push.accept)
        begin
            head_valid_next = push.has_first;
            tail_valid_next = push.has_second;
            head_next       = first_res;
            tail_next       = second_res;
        end
        else if (pop)
        begin
            head_valid_next = tail_valid_reg;
            tail_valid_next = 1'b0;
            head_next       = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ src/life_checker.sv @@
module life_checker
    import life_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  last_row,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [ROW_BITS-1:0]   next_cells,
    input logic                  grid_done,
    input logic                  run_end
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_cells)
            && $stable(grid_done) && $stable(run_end))
        else $error("stalled result changed");

    // A bottom row always gives a result on the next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_row |=> out_valid)
        else $error("bottom row gave no result");

    // The first of two results is followed at once by the bottom row
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_end |=> out_valid && grid_done && run_end)
        else $error("bottom-row result missing after row above");

    // With a second result pending the input is held off
    a_pending_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_end |-> in_stall)
        else $error("input taken while queue full");

    // The grid's bottom result always ends its run
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_done |-> run_end && !$isunknown(next_cells))
        else $error("grid_done without run_end");

endmodule

bind life_cellular_automaton_row_step_core life_checker u_life_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import life_pkg::*;

    localparam int BIRTH_COUNT    = 3;
    localparam int SURVIVE_COUNT  = 2;
    localparam int DIRECTED_COUNT = 22;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ROWS     = 110;
    localparam int SETTLE_CYCLES  = 4;
    // Corner widths for the first phases, phase 0 in the lowest bits
    localparam logic [8*WIDTH_BITS-1:0] CORNER_WIDTHS =
        {7'd3, 7'd63, 7'd65, 7'd2, 7'd127, 7'd1, 7'd0, 7'd64};

    typedef enum logic {CHECK_MODEL, CHECK_TYPED} check_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                last;
        check_t              check;
        logic [ROW_BITS-1:0] typed_cells;
    } directed_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wen    = 1'b0;
    logic [WIDTH_BITS-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [ROW_BITS-1:0]   row_cells  = '0;
    logic                  last_row   = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [ROW_BITS-1:0]   next_cells;
    logic                  grid_done;
    logic                  run_end;

    // Generation state mirrored from the block
    logic [WIDTH_BITS-1:0] life_width  = WIDTH_RESET;
    logic [ROW_BITS-1:0]   kept_upper  = '0;
    logic [ROW_BITS-1:0]   kept_middle = '0;
    logic [1:0]            kept_count  = '0;

    result_t       pending_rows[$];
    directed_row_t stim_table[DIRECTED_COUNT];
    int            mismatch_count = 0;
    int            idle_mode      = 0;
    int            stall_mode     = 0;
    int            burst_left     = 0;
    int            stall_run      = 0;
    int            stall_tick     = 0;

    life_cellular_automaton_row_step_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_cells  (row_cells),
        .last_row   (last_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_cells (next_cells),
        .grid_done  (grid_done),
        .run_end    (run_end)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Columns in use, saturated at the full row
    function automatic logic [ROW_BITS-1:0] live_column_mask(input logic [WIDTH_BITS-1:0] w);
        if (w >= ROW_BITS)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // Next state of one row from its neighbours above and below
    function automatic logic [ROW_BITS-1:0] next_generation(
        input logic [ROW_BITS-1:0] above,
        input logic [ROW_BITS-1:0] here,
        input logic [ROW_BITS-1:0] below,
        input logic [ROW_BITS-1:0] mask
    );
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] h;
        logic [ROW_BITS-1:0] b;
        logic [ROW_BITS-1:0] born;
        int                  n;
        a    = above & mask;
        h    = here & mask;
        b    = below & mask;
        born = '0;
        for (int c = 0; c < ROW_BITS; c++)
        begin
            n = a[c] + b[c];
            if (c > 0)
                n += a[c-1] + h[c-1] + b[c-1];
            if (c < ROW_BITS - 1)
                n += a[c+1] + h[c+1] + b[c+1];
            born[c] = (n == BIRTH_COUNT) || (h[c] && n == SURVIVE_COUNT);
        end
        return born & mask;
    endfunction

    // Advance the mirrored state by one row; queue its results when asked
    task automatic predict_generation(input logic [ROW_BITS-1:0] cells, input logic last,
                                      input logic record);
        logic [ROW_BITS-1:0] mask;
        logic [ROW_BITS-1:0] cur;
        logic [ROW_BITS-1:0] above;
        mask = live_column_mask(life_width);
        cur  = cells & mask;
        if (kept_count == 2'd0)
        begin
            if (last)
            begin
                if (record)
                    pending_rows.push_back({next_generation('0, cur, '0, mask), 1'b1, 1'b1});
            end
            else
            begin
                kept_middle = cur;
                kept_count  = 2'd1;
            end
            kept_upper = '0;
            if (last)
                kept_middle = '0;
        end
        else
        begin
            above = (kept_count >= 2'd2) ? kept_upper : '0;
            if (record)
                pending_rows.push_back({next_generation(above, kept_middle, cur, mask),
                                        1'b0, !last});
            if (last)
            begin
                if (record)
                    pending_rows.push_back({next_generation(kept_middle, cur, '0, mask),
                                            1'b1, 1'b1});
                kept_upper  = '0;
                kept_middle = '0;
                kept_count  = 2'd0;
            end
            else
            begin
                kept_upper  = kept_middle;
                kept_middle = cur;
                kept_count  = 2'd2;
            end
        end
    endtask

    // Offer one row, idling between bursts when an idle mode is set, and hold it until accepted
    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic last,
                            input logic use_model, input logic [ROW_BITS-1:0] typed_cells);
        int gap;
        @(negedge clk);
        if (idle_mode != 0 && burst_left == 0)
        begin
            gap = (idle_mode == 1) ? $urandom_range(1, 3) : $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid  <= 1'b1;
        row_cells <= cells;
        last_row  <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left > 0)
            burst_left--;
        predict_generation(cells, last, use_model);
        if (!use_model && last)
            pending_rows.push_back({typed_cells, 1'b1, 1'b1});
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_row_width(input logic [WIDTH_BITS-1:0] w);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_wen    <= 1'b0;
        life_width = w;
    endtask

    function automatic logic [ROW_BITS-1:0] random_row;
        logic [ROW_BITS-1:0] r1;
        logic [ROW_BITS-1:0] r2;
        logic [ROW_BITS-1:0] r3;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        r3 = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0, 1: return r1;
            2:    return r1 & r2 & r3;
            3:    return r1 | r2;
            4:    return '0;
            5:    return '1;
            default: return r1 & (64'hFF << $urandom_range(0, 56));
        endcase
    endfunction

    // Receiver stall pattern, chosen per phase
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_tick++;
            case (stall_mode)
                1: out_stall <= ($urandom_range(0, 99) < 35);
                2: out_stall <= ((stall_tick % 7) < 3);
                3:
                begin
                    if (stall_run > 0)
                    begin
                        stall_run--;
                        out_stall <= 1'b1;
                    end
                    else
                    begin
                        if ($urandom_range(0, 9) == 0)
                            stall_run = $urandom_range(1, 8);
                        out_stall <= 1'b0;
                    end
                end
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("unexpected result: next_cells %h grid_done %b run_end %b",
                       next_cells, grid_done, run_end);
                mismatch_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (next_cells !== want.cells)
                begin
                    $error("next_cells: expected %h, actual %h", want.cells, next_cells);
                    mismatch_count++;
                end
                if (grid_done !== want.grid_done)
                begin
                    $error("grid_done: expected %b, actual %b", want.grid_done, grid_done);
                    mismatch_count++;
                end
                if (run_end !== want.run_end)
                begin
                    $error("run_end: expected %b, actual %b", want.run_end, run_end);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int                  rows_sent;
        int                  grid_rows;
        int                  pick;
        logic [WIDTH_BITS-1:0] w;

        // Single-row grids, then short grids: blinker, block, full, stripes, glider; then one more single-row grid
        stim_table[0]  = {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, CHECK_TYPED, 64'h0000_0000_7FFF_FFFE};
        stim_table[1]  = {64'h0000_0000_0000_0000, 1'b1, CHECK_TYPED, 64'h0};
        stim_table[2]  = {64'h0000_0000_0000_0001, 1'b1, CHECK_TYPED, 64'h0};
        stim_table[3]  = {64'h8000_0000_8000_0000, 1'b1, CHECK_TYPED, 64'h0};
        stim_table[4]  = {64'h0000_0000_0000_0000, 1'b0, CHECK_TYPED, 64'h0};
        stim_table[5]  = {64'h0000_0000_0000_0007, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[6]  = {64'h0000_0000_0000_0000, 1'b1, CHECK_MODEL, 64'h0};
        stim_table[7]  = {64'h0000_0000_C000_0000, 1'b0, CHECK_TYPED, 64'h0};
        stim_table[8]  = {64'h0000_0000_C000_0000, 1'b1, CHECK_MODEL, 64'h0};
        stim_table[9]  = {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHECK_TYPED, 64'h0};
        stim_table[10] = {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[11] = {64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[12] = {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, CHECK_MODEL, 64'h0};
        stim_table[13] = {64'hAAAA_AAAA_AAAA_AAAA, 1'b0, CHECK_TYPED, 64'h0};
        stim_table[14] = {64'h5555_5555_5555_5555, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[15] = {64'hAAAA_AAAA_AAAA_AAAA, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[16] = {64'h5555_5555_5555_5555, 1'b1, CHECK_MODEL, 64'h0};
        stim_table[17] = {64'h0000_0000_0000_0002, 1'b0, CHECK_TYPED, 64'h0};
        stim_table[18] = {64'h0000_0000_0000_0004, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[19] = {64'h0000_0000_0000_0007, 1'b0, CHECK_MODEL, 64'h0};
        stim_table[20] = {64'h0000_0000_0000_0000, 1'b1, CHECK_MODEL, 64'h0};
        stim_table[21] = {64'hFFFF_FFFF_0000_0000, 1'b1, CHECK_TYPED, 64'h0};

        // Hold reset, then release it away from the rising edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows at the reset width
        stall_mode = 1;
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_row(stim_table[i].cells, stim_table[i].last,
                     stim_table[i].check == CHECK_MODEL, stim_table[i].typed_cells);

        // Random grids, one width and one idling pattern per phase
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            w = (p < 8) ? CORNER_WIDTHS[p*WIDTH_BITS +: WIDTH_BITS]
                        : WIDTH_BITS'($urandom_range(0, 127));
            write_row_width(w);
            idle_mode  = p % 3;
            stall_mode = (p + 1) % 4;
            burst_left = 0;
            rows_sent  = 0;
            while (rows_sent < PHASE_ROWS)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    grid_rows = 1;
                else if (pick < 8)
                    grid_rows = $urandom_range(2, 6);
                else
                    grid_rows = $urandom_range(10, 24);
                for (int r = 0; r < grid_rows; r++)
                    send_row(random_row(), r == grid_rows - 1, 1'b1, '0);
                rows_sent += grid_rows;
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_rows.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
